[hdl/deq_pkg.sv]
// Types and codes shared by the double-ended queue and its storage cells.
// No dependencies.
`default_nettype none

package deq_pkg;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_DUMP       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_ROTATE
	} deq_op_t;

	typedef struct packed {
		deq_op_t            op;
		logic signed [31:0] push_data;
		logic signed [31:0] head_data;
	} deq_ctl_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] data_in;
	} deq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic [4:0]         position;
		logic               last_of_run;
	} deq_result_t;

endpackage

`default_nettype wire

[hdl/double_ended_queue.sv]
// Double-ended queue top level: command decode, dump sequencing, result register.
// Depends on deq_pkg and deq_cell.
//
// Usage: drive req (cmd, data_in) and raise start; the request is taken at a
// rising edge where start is high and busy is low. Entries sit in a row of
// CAPACITY cells, front in cell 0; push front and pop front shift entries
// between neighboring cells, while push back and pop back work at the back end.
// Push and pop give one result, on result with result_valid high for one
// cycle, the cycle after the request is taken; a new request can be taken in
// every cycle. A dump of N entries holds busy until its last step and emits one
// entry per cycle from front to back, rotating the cell row by one place each
// cycle so the entry to emit is always in cell 0; after N steps the row is
// back in order. A dump of an empty queue gives a single empty result with no
// busy time. Commands 5 to 7 are taken and give no result.
// Push, pop and an empty dump give their result in the cycle after the request;
// a dump first raises busy, then each entry goes through the result register.
// Throughput: one request per cycle, except that no request is taken while a
// dump holds busy high.
// Reset empties the queue. Results cannot be held off by the receiver.
`default_nettype none

module double_ended_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire deq_pkg::deq_req_t      req,
	output logic                        result_valid,
	output deq_pkg::deq_result_t        result
);
	import deq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	deq_ctl_t           ctl;
	logic signed [31:0] cell_data [CAPACITY];
	logic               cell_occ  [CAPACITY];
	logic               cell_last [CAPACITY];
	logic signed [31:0] back_data;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;
	logic               dump_q;
	logic               result_valid_q;
	deq_result_t        result_q;

	logic               accept;
	logic               empty;
	logic               full;

	assign accept = start && !dump_q;
	assign empty  = (count_q == '0);
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		ctl.op        = OP_HOLD;
		ctl.push_data = req.data_in;
		ctl.head_data = cell_data[0];
		if (dump_q) begin
			ctl.op = OP_ROTATE;
		end else if (accept) begin
			case (req.cmd)
				CMD_PUSH_FRONT: if (!full)  ctl.op = OP_PUSH_FRONT;
				CMD_PUSH_BACK:  if (!full)  ctl.op = OP_PUSH_BACK;
				CMD_POP_FRONT:  if (!empty) ctl.op = OP_POP_FRONT;
				CMD_POP_BACK:   if (!empty) ctl.op = OP_POP_BACK;
				default:        ctl.op = OP_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_data  ((i == 0) ? req.data_in : cell_data[(i == 0) ? 0 : i - 1]),
			.left_occ   ((i == 0) ? 1'b1 : cell_occ[(i == 0) ? 0 : i - 1]),
			.right_data ((i == CAPACITY - 1) ? 32'sd0
			             : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.right_occ  ((i == CAPACITY - 1) ? 1'b0
			             : cell_occ[(i == CAPACITY - 1) ? i : i + 1]),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.is_last    (cell_last[i])
		);
	end

	always_comb begin
		back_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_data = back_data | (cell_last[i] ? cell_data[i] : 32'sd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			pos_q          <= '0;
			dump_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (dump_q) begin
				result_valid_q <= 1'b1;
				pos_q          <= pos_q + 1'b1;
				if (pos_q == count_q) begin
					dump_q <= 1'b0;
				end
			end else if (accept) begin
				case (req.cmd)
					CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
						result_valid_q <= 1'b1;
						if (!full) count_q <= count_q + 1'b1;
					end
					CMD_POP_FRONT, CMD_POP_BACK: begin
						result_valid_q <= 1'b1;
						if (!empty) count_q <= count_q - 1'b1;
					end
					CMD_DUMP: begin
						if (empty) begin
							result_valid_q <= 1'b1;
						end else begin
							dump_q <= 1'b1;
							pos_q  <= CW'(1);
						end
					end
					default: result_valid_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q.status      <= ST_OK;
		result_q.data_out    <= '0;
		result_q.position    <= '0;
		result_q.last_of_run <= 1'b1;
		if (dump_q) begin
			result_q.data_out    <= cell_data[0];
			result_q.position    <= 5'(pos_q);
			result_q.last_of_run <= (pos_q == count_q);
		end else if (accept) begin
			case (req.cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (full) result_q.status <= ST_FULL;
				end
				CMD_POP_FRONT: begin
					if (empty) result_q.status <= ST_EMPTY;
					else       result_q.data_out <= cell_data[0];
				end
				CMD_POP_BACK: begin
					if (empty) result_q.status <= ST_EMPTY;
					else       result_q.data_out <= back_data;
				end
				CMD_DUMP: begin
					if (empty) result_q.status <= ST_EMPTY;
				end
				default: result_q.status <= ST_OK;
			endcase
		end
	end

	assign busy         = dump_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	logic [CW-1:0] occ_ones;
	always_comb begin
		occ_ones = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			occ_ones = occ_ones + CW'(cell_occ[i]);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_ones == count_q)
		else $error("cell occupancy disagrees with entry count");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |-> (count_q != '0) && (pos_q <= count_q))
		else $error("dump step outside the stored entries");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty && (req.cmd == CMD_POP_FRONT || req.cmd == CMD_POP_BACK))
		|=> result_valid && result.status == ST_EMPTY)
		else $error("pop of empty queue did not report empty");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
		|=> result_valid && result.status == ST_FULL && $stable(count_q))
		else $error("push to full queue was not refused");

endmodule

`default_nettype wire

[hdl/deq_cell.sv]
// One storage cell of the queue chain: an entry and its occupied flag.
// Depends on deq_pkg.
`default_nettype none

module deq_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire deq_pkg::deq_ctl_t     ctl,
	input  wire logic signed [31:0]    left_data,
	input  wire logic                  left_occ,
	input  wire logic signed [31:0]    right_data,
	input  wire logic                  right_occ,
	output logic signed [31:0]         data,
	output logic                       occ,
	output logic                       is_last
);
	import deq_pkg::*;

	logic signed [31:0] data_q;
	logic               occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_PUSH_FRONT: occ_q <= left_occ;
				OP_PUSH_BACK:  if (left_occ) occ_q <= 1'b1;
				OP_POP_FRONT:  occ_q <= right_occ;
				OP_POP_BACK:   if (!right_occ) occ_q <= 1'b0;
				default:       occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH_FRONT: data_q <= left_data;
			OP_PUSH_BACK:  if (left_occ && !occ_q) data_q <= ctl.push_data;
			OP_POP_FRONT:  data_q <= right_data;
			OP_ROTATE:     if (occ_q) data_q <= right_occ ? right_data : ctl.head_data;
			default:       data_q <= data_q;
		endcase
	end

	assign data    = data_q;
	assign occ     = occ_q;
	assign is_last = occ_q && !right_occ;

endmodule

`default_nettype wire

[bench/double_ended_queue_test.sv]
// Self-checking bench for double_ended_queue: directed corner cases, then random
// fill, drain and mixed command runs, checked against an in-bench deque model.
// Depends on deq_pkg and the double_ended_queue RTL.
`default_nettype none

module double_ended_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int DEPTH = 16;
	localparam int ITEMS = 270;

	class deque_mirror;
		logic signed [31:0] slots [DEPTH];
		int unsigned        head = 0;
		int unsigned        fill = 0;
		deq_result_t        owed [$];
		int unsigned        faults = 0;

		function deq_result_t make(logic [1:0] st, logic signed [31:0] d, logic [4:0] pos,
				logic last);
			deq_result_t x;
			x.status      = st;
			x.data_out    = d;
			x.position    = pos;
			x.last_of_run = last;
			return x;
		endfunction

		function void accept_request(deq_req_t r);
			int unsigned idx;
			case (r.cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
					if (fill >= DEPTH) begin
						owed.push_back(make(ST_FULL, '0, '0, 1'b1));
					end else begin
						if (r.cmd == CMD_PUSH_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
							slots[head] = r.data_in;
						end else begin
							slots[(head + fill) % DEPTH] = r.data_in;
						end
						fill++;
						owed.push_back(make(ST_OK, '0, '0, 1'b1));
					end
				end
				CMD_POP_FRONT, CMD_POP_BACK: begin
					if (fill == 0) begin
						owed.push_back(make(ST_EMPTY, '0, '0, 1'b1));
					end else begin
						if (r.cmd == CMD_POP_FRONT) begin
							idx = head;
							head = (head + 1) % DEPTH;
						end else begin
							idx = (head + fill - 1) % DEPTH;
						end
						fill--;
						if (fill == 0)
							head = 0;
						owed.push_back(make(ST_OK, slots[idx], '0, 1'b1));
					end
				end
				CMD_DUMP: begin
					if (fill == 0) begin
						owed.push_back(make(ST_EMPTY, '0, '0, 1'b1));
					end else begin
						for (int k = 0; k < fill; k++)
							owed.push_back(make(ST_OK, slots[(head + k) % DEPTH], 5'(k + 1),
								(k + 1 == fill)));
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(deq_result_t got);
			deq_result_t want;
			if (owed.size() == 0) begin
				$error("unexpected result: status %0d data_out %0d position %0d last_of_run %0d",
					got.status, got.data_out, got.position, got.last_of_run);
				faults++;
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				faults++;
			end
			if (got.data_out !== want.data_out) begin
				$error("data_out: expected %0d, actual %0d", want.data_out, got.data_out);
				faults++;
			end
			if (got.position !== want.position) begin
				$error("position: expected %0d, actual %0d", want.position, got.position);
				faults++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d", want.last_of_run,
					got.last_of_run);
				faults++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	deq_req_t    req = '0;
	logic        result_valid;
	deq_result_t result;

	deque_mirror mirror;
	bit          burst;
	int          sent;

	double_ended_queue #(.CAPACITY(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** double_ended_queue: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				mirror.check_result(result);
			end else if (result_valid !== 1'b0) begin
				$error("result_valid: expected 0 or 1, actual %b", result_valid);
				mirror.faults++;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
	endfunction

	// hold start until busy is low at an edge
	task automatic issue(input logic [2:0] c, input logic signed [31:0] d);
		deq_req_t r;
		r.cmd = c;
		r.data_in = d;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		mirror.accept_request(r);
	endtask

	task automatic send(input logic [2:0] c, input logic signed [31:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			req.data_in <= $urandom;
			repeat (gap) @(posedge clk);
		end
		issue(c, d);
		if (c <= CMD_DUMP)
			sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (mirror.owed.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int mode;
		int n;
		int r;
		mirror = new;
		sent = 0;
		burst = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_DUMP, '0);
		send(CMD_POP_FRONT, '0);
		send(CMD_POP_BACK, '0);
		send(CMD_PUSH_BACK, 32'sh7fff_ffff);
		send(CMD_PUSH_FRONT, 32'sh8000_0000);
		send(CMD_PUSH_BACK, 32'sh5555_aaaa);
		send(CMD_DUMP, '0);
		send(CMD_POP_BACK, '0);
		send(CMD_POP_FRONT, '0);
		send(CMD_POP_FRONT, '0);
		send(CMD_PUSH_FRONT, -32'sd1);
		send(CMD_POP_BACK, '0);
		send(CMD_PUSH_BACK, '0);
		send(CMD_POP_FRONT, '0);
		send(3'd5, $urandom);
		send(3'd6, $urandom);
		send(3'd7, $urandom);
		send(CMD_DUMP, '0);
		settle();

		while (sent < ITEMS) begin
			mode = $urandom_range(0, 2);
			burst = ($urandom_range(0, 3) == 0);
			case (mode)
				0: begin
					while (mirror.fill < DEPTH) begin
						send(pick_push(), pick_word());
						if ($urandom_range(0, 9) == 0)
							send(CMD_DUMP, '0);
					end
					repeat ($urandom_range(1, 2)) send(pick_push(), pick_word());
					if ($urandom_range(0, 1))
						send(CMD_DUMP, '0);
				end
				1: begin
					while (mirror.fill > 0) begin
						send(pick_pop(), '0);
						if ($urandom_range(0, 9) == 0)
							send(CMD_DUMP, '0);
					end
					repeat ($urandom_range(1, 2)) send(pick_pop(), '0);
					if ($urandom_range(0, 1))
						send(CMD_DUMP, '0);
				end
				default: begin
					n = $urandom_range(5, 20);
					repeat (n) begin
						r = $urandom_range(0, 99);
						if (r < 42)
							send(pick_push(), pick_word());
						else if (r < 80)
							send(pick_pop(), '0);
						else if (r < 94)
							send(CMD_DUMP, '0);
						else
							send(3'($urandom_range(5, 7)), pick_word());
					end
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				settle();
		end

		start <= 1'b0;
		@(posedge clk);
		while (mirror.owed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mirror.faults == 0)
			$display("** double_ended_queue: PASSED **");
		else
			$display("** double_ended_queue: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
